### src/spectrum_bin_peak_normalizer_core_defines.svh
// assertion macros used by the top-level rtl file
`ifndef SPECTRUM_BIN_PEAK_NORMALIZER_CORE_DEFINES_SVH
`define SPECTRUM_BIN_PEAK_NORMALIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked with reset masked
`define SBPN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, also in reset
`define SBPN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBPN_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBPN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/sbpn_pkg.sv
// shared types and constants of the spectrum bin peak normalizer
package sbpn_pkg;

  localparam int unsigned MAG_W  = 32;
  localparam int unsigned Q16_W  = 17;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 32;

  localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_EQ_INTERCEPT  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_EQ_SLOPE      = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_DECAY     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_PEAK_DECAY    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_CUT_THRESHOLD = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_NOISE_FLOOR   = 3'd5;

  // reset values
  localparam logic [15:0]       RST_EQ_INTERCEPT  = 16'd16384;
  localparam logic [15:0]       RST_EQ_SLOPE      = 16'd0;
  localparam logic [Q16_W-1:0]  RST_MAX_DECAY     = 17'd65208;
  localparam logic [Q16_W-1:0]  RST_PEAK_DECAY    = 17'd62915;
  localparam logic [Q16_W-1:0]  RST_CUT_THRESHOLD = 17'd32768;
  localparam logic [MAG_W-1:0]  RST_NOISE_FLOOR   = 32'd6554;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       bin_index;
    logic [Q16_W-1:0] norm_value;
    logic [Q16_W-1:0] peak_hold;
    logic             below_threshold;
    logic [Q16_W-1:0] frame_peak_average;
    logic             last_bin;
  } out_item_t;

endpackage

### src/sbpn_if.sv
// stream interfaces for bin magnitudes in and results out
interface sbpn_in_if;
  logic                 valid;
  logic                 ready;
  sbpn_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbpn_out_if;
  logic                 valid;
  logic                 ready;
  sbpn_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/sbpn_cdiv.sv
// divide by a constant: reciprocal multiply then one correction, two stages
module sbpn_cdiv #(
  parameter int unsigned W = 25,
  parameter int unsigned D = 256
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] x_i,
  output logic [W-1:0] q_o
);

  localparam logic [W:0] RECIP = (W+1)'((64'd1 << W) / D);

  logic [2*W:0] prod;
  logic [W-1:0] x_q;
  logic [W:0]   p_q;
  logic [W:0]   rem;
  logic [W-1:0] q_q;

  // estimate is exact or one low
  assign prod = (2*W+1)'(x_i) * (2*W+1)'(RECIP);
  assign rem  = (W+1)'(x_q) - (W+1)'(p_q * (W+1)'(D));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_i;
      p_q <= prod[2*W:W];
      q_q <= W'(p_q) + W'(rem >= (W+1)'(D));
    end
  end

  assign q_o = q_q;

endmodule

### src/sbpn_div.sv
// pipelined restoring divider, one quotient bit per stage, num <= den
module sbpn_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic [16:0] quo_o
);

  localparam int unsigned NSTG = 17;

  logic [31:0] rem_q [NSTG];
  logic [31:0] den_q [NSTG];
  logic [16:0] quo_q [NSTG];
  logic [31:0] rem_d [NSTG];
  logic [16:0] quo_d [NSTG];

  always_comb begin
    logic [32:0] cur;
    logic [31:0] dv;
    logic [16:0] qp;
    logic        ge;
    for (int k = 0; k < NSTG; k++) begin
      if (k == 0) begin
        cur = {1'b0, num_i};
        dv  = den_i;
        qp  = '0;
      end else begin
        cur = {rem_q[k-1], 1'b0};
        dv  = den_q[k-1];
        qp  = quo_q[k-1];
      end
      ge       = (cur >= {1'b0, dv});
      rem_d[k] = ge ? 32'(cur - {1'b0, dv}) : 32'(cur);
      quo_d[k] = {qp[15:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NSTG; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= (k == 0) ? den_i : den_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[NSTG-1];

endmodule

### src/spectrum_bin_peak_normalizer_core.sv
// top level of the spectrum bin peak normalizer
//
// in_i carries one bin magnitude (unsigned Q16.16) per transfer, bins in
// order 0..BINS-1, frames back to back. out_o returns one result per bin:
// normalized value, peak hold, below-threshold flag, and on the last bin of
// a frame the mean peak hold. cfg_we_i writes register cfg_idx_i at the
// clock edge; write only while no bin is in flight.
// throughput: one bin per cycle unless stalled; the per-bin stores are read
// at stage 4 and the peak store written back at stage 23, so with BINS below
// 25 a bin waits at the input until the previous visit of that bin is written.
// reset: configuration registers return to defaults, then the per-bin max
// and peak stores are cleared one entry per cycle with in_i not ready.
// stall: an output register plus one skid entry; while out_o is stalled
// the pipeline still moves until the skid entry holds an item, then freezes
// with nothing lost or repeated.
`include "spectrum_bin_peak_normalizer_core_defines.svh"

module spectrum_bin_peak_normalizer_core #(
  parameter int unsigned BINS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sbpn_in_if.sink                        in_i,
  sbpn_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [sbpn_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [sbpn_pkg::CDAT_W-1:0]    cfg_wdata_i
);

  localparam int unsigned BW   = $clog2(BINS);
  localparam int unsigned DEN  = BINS - 1;
  localparam int unsigned NW   = 17 + BW;     // tilt numerator width
  localparam int unsigned SW   = 17 + BW;     // peak sum width
  localparam int unsigned NST  = 27;          // pipeline stages
  localparam int unsigned HZ_N = 24;          // stages up to peak writeback
  localparam int unsigned QW   = sbpn_pkg::Q16_W;

  // configuration registers
  logic [15:0]        cfg_icpt_q;
  logic signed [15:0] cfg_slope_q;
  logic [QW-1:0]      cfg_mdec_q;
  logic [QW-1:0]      cfg_pdec_q;
  logic [QW-1:0]      cfg_cut_q;
  logic [31:0]        cfg_nf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_icpt_q  <= sbpn_pkg::RST_EQ_INTERCEPT;
      cfg_slope_q <= sbpn_pkg::RST_EQ_SLOPE;
      cfg_mdec_q  <= sbpn_pkg::RST_MAX_DECAY;
      cfg_pdec_q  <= sbpn_pkg::RST_PEAK_DECAY;
      cfg_cut_q   <= sbpn_pkg::RST_CUT_THRESHOLD;
      cfg_nf_q    <= sbpn_pkg::RST_NOISE_FLOOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbpn_pkg::CFG_EQ_INTERCEPT:  cfg_icpt_q  <= cfg_wdata_i[15:0];
        sbpn_pkg::CFG_EQ_SLOPE:      cfg_slope_q <= cfg_wdata_i[15:0];
        sbpn_pkg::CFG_MAX_DECAY:     cfg_mdec_q  <= cfg_wdata_i[QW-1:0];
        sbpn_pkg::CFG_PEAK_DECAY:    cfg_pdec_q  <= cfg_wdata_i[QW-1:0];
        sbpn_pkg::CFG_CUT_THRESHOLD: cfg_cut_q   <= cfg_wdata_i[QW-1:0];
        sbpn_pkg::CFG_NOISE_FLOOR:   cfg_nf_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // factors above one act as one
  logic [QW-1:0] mdec_c, pdec_c, cut_c;
  assign mdec_c = (cfg_mdec_q > sbpn_pkg::ONE_Q16) ? sbpn_pkg::ONE_Q16 : cfg_mdec_q;
  assign pdec_c = (cfg_pdec_q > sbpn_pkg::ONE_Q16) ? sbpn_pkg::ONE_Q16 : cfg_pdec_q;
  assign cut_c  = (cfg_cut_q > sbpn_pkg::ONE_Q16) ? sbpn_pkg::ONE_Q16 : cfg_cut_q;

  // control: global advance, clear pass, bin counter, hazard guard
  logic          en;
  logic          skid_vld_q;
  logic          clr_q;
  logic [BW-1:0] clr_addr_q;
  logic [BW-1:0] bin_cnt_q;
  logic          hazard;
  logic          in_xfer;

  logic          vld_q  [NST];
  logic [BW-1:0] bin_q  [NST];
  logic          last_q [NST];

  assign en = !skid_vld_q;

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < HZ_N; k++) begin
      if (vld_q[k] && (bin_q[k] == bin_cnt_q)) hazard = 1'b1;
    end
  end

  assign in_i.ready = en && !clr_q && !hazard;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      bin_cnt_q  <= '0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == BW'(DEN)) clr_q <= 1'b0;
      end
      if (in_xfer) begin
        bin_cnt_q <= (bin_cnt_q == BW'(DEN)) ? '0 : bin_cnt_q + 1'b1;
      end
    end
  end

  // valid bits travel with bin tag and last flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_xfer;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bin_q[0]  <= bin_cnt_q;
      last_q[0] <= (bin_cnt_q == BW'(DEN));
      for (int k = 1; k < NST; k++) begin
        bin_q[k]  <= bin_q[k-1];
        last_q[k] <= last_q[k-1];
      end
    end
  end

  // stages 0..4: magnitude line and tilt gain
  logic [31:0]        mag_q [5];
  logic [NW-1:0]      prod_i_q;
  logic signed [NW:0] prod_s_q;
  logic signed [NW:0] slope_x, bin_x, num_s;
  logic [NW-1:0]      num_q;
  logic [NW-1:0]      gain_full;

  assign slope_x = (NW+1)'(cfg_slope_q);
  assign bin_x   = $signed({1'b0, NW'(bin_q[0])});
  assign num_s   = $signed({1'b0, prod_i_q}) + prod_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q[0] <= in_i.data.magnitude;
      for (int k = 1; k < 5; k++) mag_q[k] <= mag_q[k-1];
      prod_i_q <= NW'(cfg_icpt_q) * NW'(DEN);
      prod_s_q <= slope_x * bin_x;
      // a negative numerator clamps the gain to zero
      num_q    <= num_s[NW] ? '0 : num_s[NW-1:0];
    end
  end

  // gain = numerator / (BINS-1), ready at stage 4
  sbpn_cdiv #(.W(NW), .D(DEN)) u_gain_div (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (num_q),
    .q_o   (gain_full)
  );

  // stage 5: scaled magnitude, per-bin store read
  logic [48:0] prod_mg;
  logic [31:0] scaled5_q, scaled6_q;
  logic [31:0] rmax_rd_q;
  logic [QW-1:0] peak_rd_q, peak_old6_q;
  logic [31:0] m6_q;

  logic [31:0]   rmax_mem [BINS];
  logic [QW-1:0] peak_mem [BINS];

  assign prod_mg = 49'(mag_q[4]) * 49'(gain_full[QW-1:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      scaled5_q <= (|prod_mg[48:46]) ? '1 : prod_mg[45:14];
      rmax_rd_q <= rmax_mem[bin_q[4]];
      peak_rd_q <= peak_mem[bin_q[4]];
    end
  end

  // stage 6: new max and kill flag
  logic [31:0] m5;
  logic        kill_q [18];  // stages 6..23

  assign m5 = (rmax_rd_q < scaled5_q) ? scaled5_q : rmax_rd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m6_q        <= m5;
      scaled6_q   <= scaled5_q;
      peak_old6_q <= peak_rd_q;
      // zero max only comes with zero scaled, where the divider would give all ones
      kill_q[0]   <= (scaled5_q < cfg_nf_q) || (m5 == '0);
      for (int k = 1; k < 18; k++) kill_q[k] <= kill_q[k-1];
    end
  end

  // stage 7: decays, running max writeback
  logic [48:0]   prod_md;
  logic [33:0]   prod_pd;
  logic [QW-1:0] pdec_q [17];  // stages 7..23
  logic [31:0]   rmax_wr;

  assign prod_md = 49'(m6_q) * 49'(mdec_c);
  assign prod_pd = 34'(peak_old6_q) * 34'(pdec_c);
  assign rmax_wr = prod_md[47:16];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdec_q[0] <= prod_pd[32:16];
      for (int k = 1; k < 17; k++) pdec_q[k] <= pdec_q[k-1];
    end
  end

  // stages 7..23: norm = scaled * 2^16 / max
  logic [16:0] quo;

  sbpn_div u_norm_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (scaled6_q),
    .den_i (m6_q),
    .quo_o (quo)
  );

  // stage 24: peak hold, peak store writeback, frame sum
  logic [QW-1:0] norm23, peak23;
  logic [QW-1:0] norm_q [3];  // stages 24..26
  logic [QW-1:0] peak_q [3];
  logic [SW-1:0] sum_q, total_q, total_d;
  logic [SW-1:0] avg_full;
  logic          wr23;

  assign norm23  = kill_q[17] ? '0 : quo;
  assign peak23  = (pdec_q[16] < norm23) ? norm23 : pdec_q[16];
  assign total_d = sum_q + SW'(peak23);
  assign wr23    = en && vld_q[23];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (wr23) begin
      sum_q <= last_q[23] ? '0 : total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      total_q   <= total_d;
      norm_q[0] <= norm23;
      peak_q[0] <= peak23;
      for (int k = 1; k < 3; k++) begin
        norm_q[k] <= norm_q[k-1];
        peak_q[k] <= peak_q[k-1];
      end
    end
  end

  // store writes: clear pass after reset, then pipeline writebacks
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      rmax_mem[clr_addr_q] <= '0;
    end else if (en && vld_q[6]) begin
      rmax_mem[bin_q[6]] <= rmax_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      peak_mem[clr_addr_q] <= '0;
    end else if (wr23) begin
      peak_mem[bin_q[23]] <= peak23;
    end
  end

  // stages 25..26: frame mean = sum / BINS
  sbpn_cdiv #(.W(SW), .D(BINS)) u_avg_div (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (total_q),
    .q_o   (avg_full)
  );

  // result assembly and output register with skid entry
  sbpn_pkg::out_item_t res;
  sbpn_pkg::out_item_t out_q, skid_q;
  logic                out_vld_q;
  logic                push;

  always_comb begin
    res.bin_index          = 8'(bin_q[NST-1]);
    res.norm_value         = norm_q[2];
    res.peak_hold          = peak_q[2];
    res.below_threshold    = (peak_q[2] < cut_c);
    res.frame_peak_average = last_q[NST-1] ? avg_full[QW-1:0] : '0;
    res.last_bin           = last_q[NST-1];
  end

  assign push = en && vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_o.ready) begin
        out_vld_q  <= skid_vld_q || push;
        skid_vld_q <= 1'b0;
      end else if (push) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_o.ready) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // checks
  `SBPN_ASSERT(a_last_is_top_bin, clk_i, rst_ni,
    out_o.valid && out_o.data.last_bin |-> out_o.data.bin_index == 8'(DEN),
    "last bin flag on a bin other than the top one")
  `SBPN_ASSERT(a_avg_only_on_last, clk_i, rst_ni,
    out_o.valid && !out_o.data.last_bin |-> out_o.data.frame_peak_average == '0,
    "frame average outside the last bin")
  `SBPN_ASSERT(a_peak_covers_norm, clk_i, rst_ni,
    out_o.valid |-> out_o.data.peak_hold >= out_o.data.norm_value,
    "peak hold below normalized value")
  `SBPN_ASSERT_ALWAYS(a_skid_needs_out, clk_i,
    skid_vld_q |-> out_vld_q,
    "skid entry filled while output register empty")

endmodule
